// ----- hdl/rcfe_pkg.sv -----
// shared types and constants for the rc channel frame encoder
package rcfe_pkg;

   localparam int SampleWidth = 12;
   localparam int CodeWidth   = 11;
   localparam int BindWidth   = 7;
   localparam int QueueDepth  = 2;
   localparam int BufWidth    = 18;
   localparam int BufCntWidth = 5;

   localparam logic [7:0] START_BYTE     = 8'h55;
   localparam logic [7:0] START_BYTE_ALT = 8'h54;
   localparam logic [BindWidth-1:0] BIND_FRAMES = 7'd100;

   localparam int ScaleMul   = 820;
   localparam int ScaleShift = 11;
   localparam int Center     = 2048;
   localparam int Offset     = 1024;
   localparam int CodeMax    = 2047;

   // item kinds
   localparam logic KIND_SAMPLE = 1'b0;
   localparam logic KIND_REBIND = 1'b1;

   // configuration register indexes
   localparam logic [2:0] CSR_PROTOCOL_NUMBER = 3'd0;
   localparam logic [2:0] CSR_PROTO_VARIANT   = 3'd1;
   localparam logic [2:0] CSR_RECEIVER_NUMBER = 3'd2;
   localparam logic [2:0] CSR_OPTION_VALUE    = 3'd3;
   localparam logic [2:0] CSR_AUTO_BIND       = 3'd4;
   localparam logic [2:0] CSR_LOW_POWER       = 3'd5;
   localparam logic [2:0] CSR_RANGE_CHECK     = 3'd6;

   // header byte positions
   localparam logic [1:0] HDR_START    = 2'd0;
   localparam logic [1:0] HDR_PROTOCOL = 2'd1;
   localparam logic [1:0] HDR_RECEIVER = 2'd2;
   localparam logic [1:0] HDR_OPTION   = 2'd3;

   typedef struct packed {
      logic [7:0] protocol_number;
      logic [2:0] proto_variant;
      logic [3:0] receiver_number;
      logic [7:0] option_value;
      logic       auto_bind;
      logic       low_power;
      logic       range_check;
   } cfg_type;

   // one channel command from front to back
   typedef struct packed {
      logic                 first;
      logic                 bind_flag;
      logic                 last_chan;
      logic [CodeWidth-1:0] code;
   } cmd_type;

endpackage

// ----- hdl/rc_channel_frame_encoder.sv -----
// top level of the rc channel frame encoder
// an accepted item is registered in the queue, then its first byte at the output
// throughput: one byte per cycle unless rsp_stall; a channel item gives 1 or 2 bytes
//   (last channel up to 3 at some counts), the first of a frame 5; a 16-channel
//   frame has 26 bytes; front takes one item per cycle until the 2-entry queue fills
// reset: synchronous, clears config registers, frame position, bind countdown,
//   queue and pending bit buffer; no clearing pass
module rc_channel_frame_encoder #(
   parameter int CHANNEL_COUNT = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   // item input
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_kind,
   input  logic [rcfe_pkg::SampleWidth-1:0] req_channel_value,
   // frame bytes out
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [7:0]                       rsp_frame_byte,
   output logic                             rsp_last_byte,
   // configuration writes
   input  logic                             csr_write_enable,
   input  logic [2:0]                       csr_index,
   input  logic [7:0]                       csr_write_data
);
   import rcfe_pkg::*;

   cfg_type cfg_ff, cfg_in;
   logic    push;
   cmd_type push_cmd;
   logic    pop;
   cmd_type head_cmd;
   logic    head_valid;
   logic    queue_full;

   // register file, only each register's width is kept
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_PROTOCOL_NUMBER: cfg_in.protocol_number = csr_write_data;
            CSR_PROTO_VARIANT:   cfg_in.proto_variant   = csr_write_data[2:0];
            CSR_RECEIVER_NUMBER: cfg_in.receiver_number = csr_write_data[3:0];
            CSR_OPTION_VALUE:    cfg_in.option_value    = csr_write_data;
            CSR_AUTO_BIND:       cfg_in.auto_bind       = csr_write_data[0];
            CSR_LOW_POWER:       cfg_in.low_power       = csr_write_data[0];
            CSR_RANGE_CHECK:     cfg_in.range_check     = csr_write_data[0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // stall input only while the command queue is full
   assign req_stall = queue_full;

   // front: scale sample, decide header and bind bit
   rcfe_front #(
      .CHANNEL_COUNT(CHANNEL_COUNT)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_kind         (req_kind),
      .req_channel_value(req_channel_value),
      .push             (push),
      .push_cmd         (push_cmd)
   );

   // decouples item intake from byte output
   rcfe_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .pop       (pop),
      .head_cmd  (head_cmd),
      .head_valid(head_valid),
      .full      (queue_full)
   );

   // back: header bytes then lsb-first packing into the output register
   rcfe_back u_back (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .head_cmd      (head_cmd),
      .head_valid    (head_valid),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_frame_byte(rsp_frame_byte),
      .rsp_last_byte (rsp_last_byte)
   );

endmodule

// ----- hdl/rcfe_front.sv -----
// front end: accepts items, scales samples, tracks frame position and bind countdown
module rcfe_front #(
   parameter int CHANNEL_COUNT = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_stall,
   input  logic                              req_kind,
   input  logic [rcfe_pkg::SampleWidth-1:0]  req_channel_value,
   output logic                              push,
   output rcfe_pkg::cmd_type                 push_cmd
);
   import rcfe_pkg::*;

   localparam int PosWidth = $clog2(CHANNEL_COUNT);

   logic [PosWidth-1:0]  pos_ff, pos_in;
   logic [BindWidth-1:0] bind_cnt_ff, bind_cnt_in;
   logic                 accept;
   logic                 first;
   logic                 last_chan;
   logic signed [12:0]   diff;
   logic signed [23:0]   prod;
   logic signed [23:0]   biased;
   logic signed [12:0]   quot;
   logic signed [13:0]   shifted;
   logic [CodeWidth-1:0] code;

   assign accept    = req_valid && !req_stall;
   assign first     = (pos_ff == '0);
   assign last_chan = (pos_ff == PosWidth'(CHANNEL_COUNT - 1));

   // centre, scale by 820/2048 rounding toward zero, offset and clamp
   always_comb begin
      diff    = $signed({1'b0, req_channel_value}) - 13'(Center);
      prod    = 24'(diff) * 24'(ScaleMul);
      biased  = prod + (prod[23] ? 24'((1 << ScaleShift) - 1) : 24'sd0);
      quot    = 13'(biased >>> ScaleShift);
      shifted = 14'(quot) + 14'(Offset);
      if (shifted < 14'sd0) begin
         code = '0;
      end else if (shifted > 14'(CodeMax)) begin
         code = CodeWidth'(CodeMax);
      end else begin
         code = shifted[CodeWidth-1:0];
      end
   end

   always_comb begin
      pos_in      = pos_ff;
      bind_cnt_in = bind_cnt_ff;
      if (accept && req_kind == KIND_REBIND) begin
         bind_cnt_in = BIND_FRAMES;
      end else if (accept) begin
         pos_in = last_chan ? '0 : pos_ff + PosWidth'(1);
         if (first && bind_cnt_ff != '0) begin
            bind_cnt_in = bind_cnt_ff - BindWidth'(1);
         end
      end
   end

   assign push               = accept && req_kind == KIND_SAMPLE;
   assign push_cmd.first     = first;
   assign push_cmd.bind_flag = first && (bind_cnt_ff != '0);
   assign push_cmd.last_chan = last_chan;
   assign push_cmd.code      = code;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         bind_cnt_ff <= '0;
      end else begin
         pos_ff      <= pos_in;
         bind_cnt_ff <= bind_cnt_in;
      end
   end

endmodule

// ----- hdl/rcfe_queue.sv -----
// short command queue between front and back
module rcfe_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  rcfe_pkg::cmd_type push_cmd,
   input  logic              pop,
   output rcfe_pkg::cmd_type head_cmd,
   output logic              head_valid,
   output logic              full
);
   import rcfe_pkg::*;

   localparam int PtrWidth = $clog2(QueueDepth);
   localparam int CntWidth = $clog2(QueueDepth + 1);

   cmd_type             mem_ff [QueueDepth];
   logic [PtrWidth-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0] cnt_ff, cnt_in;

   assign head_valid = (cnt_ff != '0);
   assign full       = (cnt_ff == CntWidth'(QueueDepth));
   assign head_cmd   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrWidth'(QueueDepth - 1)) ? '0 : wr_ptr_ff + PtrWidth'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrWidth'(QueueDepth - 1)) ? '0 : rd_ptr_ff + PtrWidth'(1);
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + CntWidth'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - CntWidth'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

// ----- hdl/rcfe_back.sv -----
// back end: emits header bytes and packs 11-bit codes into bytes
module rcfe_back (
   input  logic              clock,
   input  logic              reset,
   input  rcfe_pkg::cfg_type cfg,
   input  rcfe_pkg::cmd_type head_cmd,
   input  logic              head_valid,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [7:0]        rsp_frame_byte,
   output logic              rsp_last_byte
);
   import rcfe_pkg::*;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [7:0]             byte_ff, byte_in;
   logic                   last_ff, last_in;
   logic [1:0]             hdr_idx_ff, hdr_idx_in;
   logic                   hdr_done_ff, hdr_done_in;
   logic                   loaded_ff, loaded_in;
   logic [BufWidth-1:0]    buf_ff, buf_in;
   logic [BufCntWidth-1:0] buf_cnt_ff, buf_cnt_in;

   logic                   load_ok;
   logic                   fire;
   logic                   in_header;
   logic [BufWidth-1:0]    cur_bits;
   logic [BufCntWidth-1:0] cur_cnt;
   logic [BufCntWidth-1:0] rest_cnt;
   logic                   data_last;
   logic [7:0]             hdr_byte;

   assign load_ok   = !rsp_valid_ff || !rsp_stall;
   assign fire      = head_valid && load_ok;
   assign in_header = head_cmd.first && !hdr_done_ff;

   // merge the new code above pending bits on its first data step
   assign cur_bits  = loaded_ff ? buf_ff
                    : buf_ff | (BufWidth'(head_cmd.code) << buf_cnt_ff);
   assign cur_cnt   = loaded_ff ? buf_cnt_ff : buf_cnt_ff + BufCntWidth'(CodeWidth);
   assign rest_cnt  = (cur_cnt >= BufCntWidth'(8)) ? cur_cnt - BufCntWidth'(8) : '0;
   assign data_last = head_cmd.last_chan && (cur_cnt <= BufCntWidth'(8));

   always_comb begin
      unique case (hdr_idx_ff)
         HDR_START:    hdr_byte = (cfg.protocol_number[7:5] == 3'd0) ? START_BYTE
                                                                     : START_BYTE_ALT;
         HDR_PROTOCOL: hdr_byte = {head_cmd.bind_flag, cfg.auto_bind, cfg.range_check,
                                   cfg.protocol_number[4:0]};
         HDR_RECEIVER: hdr_byte = {cfg.low_power, cfg.proto_variant, cfg.receiver_number};
         HDR_OPTION:   hdr_byte = cfg.option_value;
         default:      hdr_byte = cfg.option_value;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      byte_in      = byte_ff;
      last_in      = last_ff;
      hdr_idx_in   = hdr_idx_ff;
      hdr_done_in  = hdr_done_ff;
      loaded_in    = loaded_ff;
      buf_in       = buf_ff;
      buf_cnt_in   = buf_cnt_ff;
      pop          = 1'b0;
      if (load_ok) begin
         rsp_valid_in = fire;
      end
      if (fire && in_header) begin
         byte_in    = hdr_byte;
         last_in    = 1'b0;
         hdr_idx_in = hdr_idx_ff + 2'd1;
         if (hdr_idx_ff == HDR_OPTION) begin
            hdr_done_in = 1'b1;
         end
      end else if (fire) begin
         byte_in = cur_bits[7:0];
         last_in = data_last;
         if (data_last) begin
            // frame complete, leftover bits go out padded in this byte
            buf_in      = '0;
            buf_cnt_in  = '0;
            loaded_in   = 1'b0;
            hdr_idx_in  = HDR_START;
            hdr_done_in = 1'b0;
            pop         = 1'b1;
         end else if (!head_cmd.last_chan && rest_cnt < BufCntWidth'(8)) begin
            buf_in      = cur_bits >> 8;
            buf_cnt_in  = rest_cnt;
            loaded_in   = 1'b0;
            hdr_idx_in  = HDR_START;
            hdr_done_in = 1'b0;
            pop         = 1'b1;
         end else begin
            buf_in     = cur_bits >> 8;
            buf_cnt_in = rest_cnt;
            loaded_in  = 1'b1;
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_frame_byte = byte_ff;
   assign rsp_last_byte  = last_ff;

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         hdr_idx_ff   <= HDR_START;
         hdr_done_ff  <= 1'b0;
         loaded_ff    <= 1'b0;
         buf_ff       <= '0;
         buf_cnt_ff   <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         hdr_idx_ff   <= hdr_idx_in;
         hdr_done_ff  <= hdr_done_in;
         loaded_ff    <= loaded_in;
         buf_ff       <= buf_in;
         buf_cnt_ff   <= buf_cnt_in;
      end
   end

endmodule

// ----- hdl/rcfe_checker.sv -----
// port-level checks for the rc channel frame encoder, bound to the top level
module rcfe_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_frame_byte,
   input logic       rsp_last_byte
);

   // nothing comes out right after reset
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("output valid after reset");

   // queue is empty after reset, so input is open
   a_reset_open: assert property (@(posedge clock) reset |=> !req_stall)
      else $error("input stalled after reset");

   // stalled byte holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_frame_byte)
                                 && $stable(rsp_last_byte))
      else $error("stalled output changed");

   // a byte right after a frame end opens the next frame with a start byte
   a_next_start: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_last_byte ##1 rsp_valid
         |-> rsp_frame_byte == 8'h55 || rsp_frame_byte == 8'h54)
      else $error("frame did not open with a start byte");

endmodule

bind rc_channel_frame_encoder rcfe_checker u_checker (.*);

// ----- tb/tb_rc_channel_frame_encoder.sv -----
// self-checking testbench for the rc channel frame encoder
`timescale 1ns / 1ps

module tb_rc_channel_frame_encoder;
   import rcfe_pkg::*;

   localparam int CHANNEL_COUNT = 16;

   // frame constants as the encoder spec gives them
   localparam logic [7:0] START_MAIN  = 8'h55;
   localparam logic [7:0] START_ALT   = 8'h54;
   localparam logic [6:0] BIND_RELOAD = 7'd100;
   localparam int SAMPLE_CENTER = 2048;
   localparam int SCALE_NUM     = 820;
   localparam int SCALE_DEN     = 2048;
   localparam int CODE_OFFSET   = 1024;
   localparam int CODE_LIMIT    = 2047;

   // cycles to let pass after the last due byte before touching registers
   localparam int SETTLE_CYCLES = 8;

   typedef struct packed {
      logic [7:0] value;
      logic       last;
   } frame_byte_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic        req_kind;
   logic [11:0] req_channel_value;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [7:0]  rsp_frame_byte;
   logic        rsp_last_byte;
   logic        csr_write_enable;
   logic [2:0]  csr_index;
   logic [7:0]  csr_write_data;

   // predictor copy of registers and frame state
   cfg_type     cfg_model;
   logic [6:0]  pend_bits;
   logic [2:0]  pend_cnt;
   logic [3:0]  chan_pos;
   logic [6:0]  bind_left;

   frame_byte_type frame_bytes_due[$];
   int          mismatch_count;
   bit          steady_flow;      // no random idling on either side
   int          rsp_hold_cycles;  // long receiver hold-off, counted down below

   rc_channel_frame_encoder #(
      .CHANNEL_COUNT(CHANNEL_COUNT)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_kind(req_kind),
      .req_channel_value(req_channel_value),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_frame_byte(rsp_frame_byte),
      .rsp_last_byte(rsp_last_byte),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   // 12 ns clock
   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   // ---------------------------------------------------------------
   // predictor
   // ---------------------------------------------------------------

   // centre, scale by 820/2048 toward zero, offset, clamp to 11 bits
   function automatic logic [10:0] scale_code(input logic [11:0] raw);
      int v;
      v = int'(raw) - SAMPLE_CENTER;
      v = (v * SCALE_NUM) / SCALE_DEN + CODE_OFFSET;
      if (v < 0)
         v = 0;
      else if (v > CODE_LIMIT)
         v = CODE_LIMIT;
      return 11'(v);
   endfunction

   function automatic void push_byte(input logic [7:0] value, input logic last);
      frame_byte_type b;
      b.value = value;
      b.last  = last;
      frame_bytes_due.push_back(b);
   endfunction

   // expected bytes for one accepted item, updates the frame state
   function automatic void encode_item(input logic kind, input logic [11:0] value);
      logic [31:0] acc;
      int          cnt;
      logic        final_chan;
      logic [7:0]  b1;
      if (kind == KIND_REBIND) begin
         // reload takes effect at once, header already out is not touched
         bind_left = BIND_RELOAD;
         return;
      end
      // header goes out ahead of the first channel
      if (chan_pos == 4'd0) begin
         push_byte((cfg_model.protocol_number < 8'd32) ? START_MAIN : START_ALT, 1'b0);
         b1 = {1'b0, cfg_model.auto_bind, cfg_model.range_check,
               cfg_model.protocol_number[4:0]};
         if (bind_left != 7'd0) begin
            bind_left = bind_left - 7'd1;
            b1[7] = 1'b1;
         end
         push_byte(b1, 1'b0);
         push_byte({cfg_model.low_power, cfg_model.proto_variant,
                    cfg_model.receiver_number}, 1'b0);
         push_byte(cfg_model.option_value, 1'b0);
      end
      final_chan = (int'(chan_pos) + 1 >= CHANNEL_COUNT);
      // 11-bit codes packed lsb first
      cnt = int'(pend_cnt);
      acc = 32'(pend_bits) | (32'(scale_code(value)) << cnt);
      cnt = cnt + 11;
      while (cnt >= 8) begin
         cnt = cnt - 8;
         push_byte(acc[7:0], final_chan && (cnt == 0));
         acc = acc >> 8;
      end
      if (final_chan) begin
         // leftover bits of the last channel padded into one closing byte
         if (cnt != 0)
            push_byte(acc[7:0], 1'b1);
         pend_bits = '0;
         pend_cnt  = '0;
         chan_pos  = '0;
      end else begin
         pend_bits = acc[6:0];
         pend_cnt  = 3'(cnt);
         chan_pos  = chan_pos + 4'd1;
      end
   endfunction

   // ---------------------------------------------------------------
   // result side: stall generation and byte checking
   // ---------------------------------------------------------------

   // receiver stalls at random, or holds off for a counted stretch
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (rsp_hold_cycles > 0) begin
         rsp_stall <= 1'b1;
         rsp_hold_cycles <= rsp_hold_cycles - 1;
      end else begin
         rsp_stall <= !steady_flow && ($urandom_range(0, 99) < 29);
      end
   end

   // every accepted byte against the oldest expectation
   always @(posedge clock) begin
      frame_byte_type due;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (frame_bytes_due.size() == 0) begin
            $error("frame_byte: no byte expected, actual %h", rsp_frame_byte);
            mismatch_count++;
         end else begin
            due = frame_bytes_due.pop_front();
            if (rsp_frame_byte !== due.value) begin
               $error("frame_byte: expected %h, actual %h", due.value, rsp_frame_byte);
               mismatch_count++;
            end
            if (rsp_last_byte !== due.last) begin
               $error("last_byte: expected %b, actual %b", due.last, rsp_last_byte);
               mismatch_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // request side and register helpers
   // ---------------------------------------------------------------

   // offers one item, with random idle cycles ahead of it, and waits for it to go in
   task automatic send_item(input logic kind, input logic [11:0] value);
      @(negedge clock);
      while (!steady_flow && ($urandom_range(0, 99) < 29)) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_kind          <= kind;
      req_channel_value <= value;
      do
         @(posedge clock);
      while (req_stall);
      encode_item(kind, value);
   endtask

   // drop valid, let every due byte arrive, then let a rebind settle
   task automatic wait_frame_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (frame_bytes_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [7:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
   endtask

   // writes every register; bits above each register's width carry junk
   task automatic set_config(input cfg_type c);
      logic [7:0] junk;
      wait_frame_idle();
      write_reg(CSR_PROTOCOL_NUMBER, c.protocol_number);
      junk = 8'($urandom);
      write_reg(CSR_PROTO_VARIANT, {junk[7:3], c.proto_variant});
      junk = 8'($urandom);
      write_reg(CSR_RECEIVER_NUMBER, {junk[7:4], c.receiver_number});
      write_reg(CSR_OPTION_VALUE, c.option_value);
      junk = 8'($urandom);
      write_reg(CSR_AUTO_BIND, {junk[7:1], c.auto_bind});
      junk = 8'($urandom);
      write_reg(CSR_LOW_POWER, {junk[7:1], c.low_power});
      junk = 8'($urandom);
      write_reg(CSR_RANGE_CHECK, {junk[7:1], c.range_check});
      @(negedge clock);
      csr_write_enable <= 1'b0;
      cfg_model = c;
   endtask

   // protocol numbers lean on the start byte boundary and the ends
   function automatic cfg_type random_config();
      cfg_type c;
      case ($urandom_range(0, 4))
         0: c.protocol_number = 8'd0;
         1: c.protocol_number = 8'd31;
         2: c.protocol_number = 8'd32;
         3: c.protocol_number = 8'd255;
         default: c.protocol_number = 8'($urandom);
      endcase
      c.proto_variant   = 3'($urandom);
      c.receiver_number = 4'($urandom);
      c.option_value    = 8'($urandom);
      c.auto_bind       = 1'($urandom);
      c.low_power       = 1'($urandom);
      c.range_check     = 1'($urandom);
      return c;
   endfunction

   // samples with the ends and the centre mixed in
   function automatic logic [11:0] pick_sample();
      case ($urandom_range(0, 9))
         0: return 12'd0;
         1: return 12'd4095;
         2: return 12'd2048;
         3: return 12'd2047;
         default: return 12'($urandom);
      endcase
   endfunction

   // ---------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------

   // registers left at their reset values, header all zeros but the start byte
   task automatic test_reset_defaults();
      send_item(KIND_SAMPLE, 12'd0);
      send_item(KIND_SAMPLE, 12'd4095);
      send_item(KIND_SAMPLE, 12'd2048);
      send_item(KIND_SAMPLE, 12'd2047);   // small negative offset truncates to centre
   endtask

   // registers at their top mid-frame, rebind mid-frame, then start byte boundary
   task automatic test_extremes_and_rebind();
      cfg_type c;
      c = '{protocol_number: 8'd255, proto_variant: 3'd7, receiver_number: 4'd15,
            option_value: 8'd255, auto_bind: 1'b1, low_power: 1'b1, range_check: 1'b1};
      // written while the frame is four channels in, header already gone
      set_config(c);
      send_item(KIND_SAMPLE, 12'd2049);
      send_item(KIND_SAMPLE, 12'd1);
      send_item(KIND_SAMPLE, 12'd4094);
      // rebind inside a frame only shows up in the next header
      send_item(KIND_REBIND, 12'd4095);
      for (int i = 0; i < 9; i++)
         send_item(KIND_SAMPLE, pick_sample());
      c = '{protocol_number: 8'd32, proto_variant: 3'd0, receiver_number: 4'd0,
            option_value: 8'd0, auto_bind: 1'b0, low_power: 1'b0, range_check: 1'b0};
      set_config(c);
      send_item(KIND_SAMPLE, 12'd2046);
      send_item(KIND_SAMPLE, 12'd2050);
   endtask

   // several register settings with random samples and rare rebinds
   task automatic test_random_settings();
      for (int p = 0; p < 7; p++) begin
         set_config(random_config());
         // one phase runs with no idling at all
         steady_flow = (p == 3);
         for (int i = 0; i < 44; i++) begin
            if ($urandom_range(0, 99) < 3)
               send_item(KIND_REBIND, 12'($urandom));
            else
               send_item(KIND_SAMPLE, pick_sample());
         end
      end
      steady_flow = 1'b0;
   endtask

   // receiver holds off long while items keep coming, so the input backs up
   task automatic test_backpressure();
      set_config(random_config());
      @(posedge clock);
      rsp_hold_cycles = 300;
      steady_flow = 1'b1;
      for (int i = 0; i < 40; i++)
         send_item(KIND_SAMPLE, pick_sample());
      steady_flow = 1'b0;
   endtask

   // rebind at a frame start, then two frames whose headers carry the bind bit
   task automatic test_bind_frames();
      set_config(random_config());
      // finish the frame in progress so the countdown lines up with headers
      while (chan_pos != 4'd0)
         send_item(KIND_SAMPLE, pick_sample());
      send_item(KIND_REBIND, 12'd0);
      for (int i = 0; i < 2 * CHANNEL_COUNT; i++)
         send_item(KIND_SAMPLE, 12'($urandom));
   endtask

   // ---------------------------------------------------------------
   // run
   // ---------------------------------------------------------------

   initial begin
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_kind          = KIND_SAMPLE;
      req_channel_value = '0;
      rsp_stall         = 1'b0;
      csr_write_enable  = 1'b0;
      csr_index         = CSR_PROTOCOL_NUMBER;
      csr_write_data    = '0;
      cfg_model         = '0;
      pend_bits         = '0;
      pend_cnt          = '0;
      chan_pos          = '0;
      bind_left         = '0;
      mismatch_count    = 0;
      steady_flow       = 1'b0;
      rsp_hold_cycles   = 0;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_defaults();
      test_extremes_and_rebind();
      test_random_settings();
      test_backpressure();
      test_bind_frames();

      // all due bytes in, plus a few cycles for anything stray
      wait_frame_idle();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   // hard stop far beyond the slowest correct run
   initial begin
      #3_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule

// ----- sim.f -----
hdl/rcfe_pkg.sv
hdl/rcfe_front.sv
hdl/rcfe_queue.sv
hdl/rcfe_back.sv
hdl/rc_channel_frame_encoder.sv
hdl/rcfe_checker.sv
tb/tb_rc_channel_frame_encoder.sv
